>>> rtl/jpc_pkg.sv
// Package with shared types, constants and the arctangent table of the joystick converter.
`timescale 1ns / 1ps

package jpc_pkg;

    localparam int RAW_W         = 8;
    localparam int SPEED_W       = 15;
    localparam int ANGLE_W       = 17;
    localparam int CFG_IDX_W     = 2;
    localparam int STEP_W        = 5;
    localparam int DIV_ITERS     = 18;
    localparam int NUM_W         = 20;
    localparam int CORDIC_ITERS  = 16;
    localparam int CORDIC_FRAC   = 16;
    localparam int CORDIC_W      = 27;
    localparam int ZACC_W        = 32;
    localparam int SQ_W          = 16;
    localparam int SPEED_INT_W   = 7;
    localparam int DEADZONE      = 5;
    localparam int SPEED_SQ_MAX  = 10000;
    localparam int SPEED_MAX     = 100;
    localparam int AXIS_SAT      = 127;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RAW_MIN     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RAW_MAX     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AXIS_OFFSET = 2'd2;

    // Axis codes
    localparam logic AXIS_X = 1'b0;
    localparam logic AXIS_Y = 1'b1;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_DIV    = 6'b000010,
        ST_COMMIT = 6'b000100,
        ST_PINIT  = 6'b001000,
        ST_POLAR  = 6'b010000,
        ST_FIN    = 6'b100000
    } jpc_state_t;

    typedef struct packed {
        logic              load;
        logic              div_step;
        logic              commit;
        logic              polar_init;
        logic              polar_step;
        logic              finish;
        logic [STEP_W-1:0] step;
    } jpc_cmd_t;

    typedef struct packed {
        logic out_free;
    } jpc_status_t;

    // atan(2^-i) in degrees, 16 fraction bits
    function automatic logic signed [ZACC_W-1:0] atan_deg(input logic [3:0] idx);
        logic signed [ZACC_W-1:0] val;
        begin
            case (idx)
                4'd0:    val = 32'sd2949120;
                4'd1:    val = 32'sd1740967;
                4'd2:    val = 32'sd919879;
                4'd3:    val = 32'sd466945;
                4'd4:    val = 32'sd234379;
                4'd5:    val = 32'sd117304;
                4'd6:    val = 32'sd58666;
                4'd7:    val = 32'sd29335;
                4'd8:    val = 32'sd14668;
                4'd9:    val = 32'sd7334;
                4'd10:   val = 32'sd3667;
                4'd11:   val = 32'sd1833;
                4'd12:   val = 32'sd917;
                4'd13:   val = 32'sd458;
                4'd14:   val = 32'sd229;
                4'd15:   val = 32'sd115;
                default: val = 32'sd0;
            endcase
            return val;
        end
    endfunction

endpackage

>>> rtl/jpc_ctrl.sv
// Controller state machine sequencing mapping, division and polar iterations.
`timescale 1ns / 1ps

module jpc_ctrl
    import jpc_pkg::*;
#(
    parameter int FRAC_BITS = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  jpc_status_t status,
    output jpc_cmd_t    cmd
);

    localparam int SQRT_ITERS  = SPEED_INT_W + FRAC_BITS;
    localparam int POLAR_ITERS = (SQRT_ITERS > CORDIC_ITERS) ? SQRT_ITERS : CORDIC_ITERS;

    jpc_state_t        state_reg, state_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;

    // Advance state and step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Decode next state and commands
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.step   = cnt_reg;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == STEP_W'(DIV_ITERS - 1))
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = ST_PINIT;
            end
            ST_PINIT:
            begin
                cmd.polar_init = 1'b1;
                cnt_next       = '0;
                state_next     = ST_POLAR;
            end
            ST_POLAR:
            begin
                cmd.polar_step = 1'b1;
                cnt_next       = cnt_reg + 1'b1;
                if (cnt_reg == STEP_W'(POLAR_ITERS - 1))
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/jpc_datapath.sv
// Datapath: config registers, axis divider, square root, CORDIC and output register.
`timescale 1ns / 1ps

module jpc_datapath
    import jpc_pkg::*;
#(
    parameter int FRAC_BITS = 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [RAW_W-1:0]     cfg_data,
    input  logic [RAW_W-1:0]     raw_byte,
    input  jpc_cmd_t             cmd,
    output jpc_status_t          status,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [SPEED_W-1:0]   speed,
    output logic [ANGLE_W-1:0]   steer_angle,
    output logic                 updated_axis
);

    localparam int SQRT_ITERS = SPEED_INT_W + FRAC_BITS;
    localparam int SQRT_W     = 2 * SQRT_ITERS;
    localparam int RND_SHIFT  = (FRAC_BITS >= CORDIC_FRAC) ? 1 : (CORDIC_FRAC - FRAC_BITS);
    localparam logic [SQRT_W-1:0] SPEED_FULL = SQRT_W'(SPEED_MAX) << FRAC_BITS;
    localparam logic signed [ZACC_W-1:0] DEG90  = ZACC_W'(90) << FRAC_BITS;
    localparam logic signed [ZACC_W-1:0] DEG180 = ZACC_W'(180) << FRAC_BITS;
    localparam logic signed [ZACC_W-1:0] Z_RND  = ZACC_W'(1) << (RND_SHIFT - 1);
    localparam logic signed [ZACC_W-1:0] Z_QTR  = ZACC_W'(90) << CORDIC_FRAC;

    // Configuration registers
    logic [RAW_W-1:0]        raw_min_reg, raw_max_reg;
    logic signed [RAW_W-1:0] axis_offset_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_min_reg     <= '0;
            raw_max_reg     <= '1;
            axis_offset_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_RAW_MIN:     raw_min_reg     <= cfg_data;
                CFG_RAW_MAX:     raw_max_reg     <= cfg_data;
                CFG_AXIS_OFFSET: axis_offset_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Axis numerator and denominator
    logic signed [RAW_W:0]   d_s, n_s;
    logic signed [NUM_W-1:0] coef_y, num_x, num_y, num_s;

    assign d_s    = $signed({1'b0, raw_byte}) - $signed({1'b0, raw_min_reg});
    assign n_s    = $signed({1'b0, raw_max_reg}) - $signed({1'b0, raw_min_reg});
    assign coef_y = 20'sd100 - (NUM_W'(axis_offset_reg) <<< 1);
    assign num_x  = NUM_W'(d_s) * 20'sd200 - NUM_W'(n_s) * 20'sd100;
    assign num_y  = coef_y * NUM_W'(n_s) - NUM_W'(d_s) * 20'sd200;

    // Phase and axis positions
    logic                    phase_reg, axis_reg;
    logic signed [RAW_W-1:0] x_reg, y_reg;
    logic [DIV_ITERS-1:0]    quo_reg;
    logic [RAW_W-1:0]        den_reg, rem_reg;
    logic                    qneg_reg, nzero_reg;
    logic [RAW_W:0]          trial;
    logic [RAW_W-1:0]        q_sat;
    logic signed [RAW_W-1:0] q_axis;

    assign num_s = (phase_reg == AXIS_Y) ? num_y : num_x;
    assign trial = {rem_reg, quo_reg[DIV_ITERS-1]};
    assign q_sat = (quo_reg > DIV_ITERS'(AXIS_SAT)) ? RAW_W'(AXIS_SAT) : quo_reg[RAW_W-1:0];
    assign q_axis = nzero_reg ? '0 : (qneg_reg ? -$signed(q_sat) : $signed(q_sat));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= AXIS_X;
            x_reg     <= '0;
            y_reg     <= '0;
        end
        else if (cmd.commit)
        begin
            phase_reg <= ~phase_reg;
            if (phase_reg == AXIS_Y)
            begin
                y_reg <= q_axis;
            end
            else
            begin
                x_reg <= q_axis;
            end
        end
    end

    // Restoring divider on magnitudes, one quotient bit per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            quo_reg   <= num_s[NUM_W-1] ? DIV_ITERS'(-num_s) : DIV_ITERS'(num_s);
            den_reg   <= n_s[RAW_W] ? RAW_W'(-n_s) : RAW_W'(n_s);
            rem_reg   <= '0;
            qneg_reg  <= num_s[NUM_W-1] ^ n_s[RAW_W];
            nzero_reg <= (n_s == '0);
            axis_reg  <= phase_reg;
        end
        else if (cmd.div_step)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_reg <= RAW_W'(trial - {1'b0, den_reg});
                quo_reg <= {quo_reg[DIV_ITERS-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[RAW_W-1:0];
                quo_reg <= {quo_reg[DIV_ITERS-2:0], 1'b0};
            end
        end
    end

    // Polar setup terms
    logic signed [SQ_W-1:0] xx, yy;
    logic [SQ_W-1:0]        sq;
    logic [RAW_W-1:0]       x_abs, y_abs;
    logic                   dz;

    assign xx    = x_reg * x_reg;
    assign yy    = y_reg * y_reg;
    assign sq    = SQ_W'(xx) + SQ_W'(yy);
    assign x_abs = x_reg[RAW_W-1] ? RAW_W'(-x_reg) : RAW_W'(x_reg);
    assign y_abs = y_reg[RAW_W-1] ? RAW_W'(-y_reg) : RAW_W'(y_reg);
    assign dz    = (x_abs < RAW_W'(DEADZONE)) && (y_abs < RAW_W'(DEADZONE));

    logic                       big_reg, dz_reg, x0_reg, y0_reg, xneg_reg, yneg_reg;
    logic [SQRT_W-1:0]          sv_reg, sr_reg, sbit_reg;
    logic signed [CORDIC_W-1:0] re_reg, im_reg, dre, dim;
    logic signed [ZACC_W-1:0]   z_reg;
    logic [SQRT_W-1:0]          s_trial;
    logic [3:0]                 ci;

    assign s_trial = sr_reg + sbit_reg;
    assign ci      = cmd.step[3:0];
    assign dre     = im_reg >>> ci;
    assign dim     = re_reg >>> ci;

    // Square root and CORDIC iterations
    always_ff @(posedge clk)
    begin
        if (cmd.polar_init)
        begin
            big_reg  <= (sq > SQ_W'(SPEED_SQ_MAX));
            dz_reg   <= dz;
            x0_reg   <= (x_reg == '0);
            y0_reg   <= (y_reg == '0);
            xneg_reg <= x_reg[RAW_W-1];
            yneg_reg <= y_reg[RAW_W-1];
            sv_reg   <= SQRT_W'(sq) << (2 * FRAC_BITS);
            sr_reg   <= '0;
            sbit_reg <= SQRT_W'(1) << (SQRT_W - 2);
            if (y_reg[RAW_W-1])
            begin
                re_reg <= CORDIC_W'(x_abs) <<< CORDIC_FRAC;
                im_reg <= CORDIC_W'(y_abs) <<< CORDIC_FRAC;
                z_reg  <= Z_QTR;
            end
            else
            begin
                re_reg <= CORDIC_W'(y_abs) <<< CORDIC_FRAC;
                im_reg <= CORDIC_W'(x_abs) <<< CORDIC_FRAC;
                z_reg  <= '0;
            end
        end
        else if (cmd.polar_step)
        begin
            if (cmd.step < STEP_W'(SQRT_ITERS))
            begin
                if (sv_reg >= s_trial)
                begin
                    sv_reg <= sv_reg - s_trial;
                    sr_reg <= (sr_reg >> 1) + sbit_reg;
                end
                else
                begin
                    sr_reg <= sr_reg >> 1;
                end
                sbit_reg <= sbit_reg >> 2;
            end
            if (cmd.step < STEP_W'(CORDIC_ITERS))
            begin
                if (im_reg > 0)
                begin
                    re_reg <= re_reg + dre;
                    im_reg <= im_reg - dim;
                    z_reg  <= z_reg + atan_deg(ci);
                end
                else
                begin
                    re_reg <= re_reg - dre;
                    im_reg <= im_reg + dim;
                    z_reg  <= z_reg - atan_deg(ci);
                end
            end
        end
    end

    // Result selection
    logic signed [ZACC_W-1:0] z_round, z_signed, angle_full;
    logic [SQRT_W-1:0]        speed_full;

    assign z_round  = (FRAC_BITS >= CORDIC_FRAC) ? z_reg : ((z_reg + Z_RND) >>> RND_SHIFT);
    assign z_signed = xneg_reg ? -z_round : z_round;

    always_comb
    begin
        if (big_reg)
            speed_full = SPEED_FULL;
        else if (dz_reg)
            speed_full = '0;
        else
            speed_full = sr_reg;

        if (x0_reg)
            angle_full = yneg_reg ? DEG180 : '0;
        else if (y0_reg)
            angle_full = xneg_reg ? -DEG90 : DEG90;
        else if (dz_reg)
            angle_full = '0;
        else
            angle_full = z_signed;
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid <= 1'b0;
        end
        else if (cmd.finish)
        begin
            m_tvalid <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            speed        <= speed_full[SPEED_W-1:0];
            steer_angle  <= angle_full[ANGLE_W-1:0];
            updated_axis <= axis_reg;
        end
    end

    assign status.out_free = !m_tvalid || m_tready;

endmodule

>>> rtl/joystick_polar_converter.sv
// Top level of the joystick byte to speed and steering angle converter.
//   channel | direction | handshake            | payload
//   s_      | in        | s_tvalid / s_tready  | s_tdata = raw_byte
//   m_      | out       | m_tvalid / m_tready  | m_tdata = speed, steer_angle; m_tuser = axis
//   cfg_    | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
// One byte at a time: 18 divider steps, 7+FRAC_BITS square root steps (at least 16
// for the CORDIC loop) and four control states per byte.
// The result sits in an output register; a new byte is taken while it waits.
// Reset clears configuration to min 0, max 255, offset 0, both axes to zero.
// A stalled result holds the block in its final state until the transfer.
`timescale 1ns / 1ps

module joystick_polar_converter
    import jpc_pkg::*;
#(
    parameter int FRAC_BITS = 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] raw_byte
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [31:0]          m_tdata,   // [14:0] speed, [31:15] steer_angle
    output logic                 m_tuser,   // [0] updated_axis
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [RAW_W-1:0]     cfg_data
);

    jpc_cmd_t           cmd;
    jpc_status_t        status;
    logic [SPEED_W-1:0] speed;
    logic [ANGLE_W-1:0] steer_angle;

    assign cfg_ready = 1'b1;
    assign m_tdata   = {steer_angle, speed};

    jpc_ctrl #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    jpc_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .raw_byte     (s_tdata),
        .cmd          (cmd),
        .status       (status),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .speed        (speed),
        .steer_angle  (steer_angle),
        .updated_axis (m_tuser)
    );

endmodule

>>> rtl/jpc_checker.sv
// Port-level checker for the joystick converter, bound to the top level.
`timescale 1ns / 1ps

module jpc_port_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tuser
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // One byte at a time: input closes after a transfer
    a_in_close: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after a transfer");

    // Reset empties the output register
    a_rst_empty: assert property (@(posedge clk)
        !rst_n |=> !m_tvalid)
        else $error("result valid during reset");

endmodule

bind joystick_polar_converter jpc_port_checker u_jpc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

>>> dv/jpc_checker.sv
// Checker for the joystick polar converter: predicts each result and compares it.
`timescale 1ns / 1ps

module jpc_checker
    import jpc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [7:0]           s_tdata,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [31:0]          m_tdata,
    input  logic                 m_tuser,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [RAW_W-1:0]     cfg_data,
    output int                   fail_count,
    output int                   pending
);

    localparam int FB = 8;

    typedef struct {
        logic [SPEED_W-1:0] speed;
        logic [ANGLE_W-1:0] angle;
        logic               axis;
    } polar_t;

    polar_t         polar_q[$];
    logic [7:0]     min_r, max_r;
    logic signed [7:0] offs_r;
    logic           phase;
    longint         xpos, ypos;

    // Map one raw byte onto an axis value with truncation and saturation
    function automatic longint map_raw(logic [7:0] raw, logic is_y);
        longint d, n, num, q;
        d = longint'(raw) - longint'(min_r);
        n = longint'(max_r) - longint'(min_r);
        if (n == 0)
            return 0;
        if (is_y)
            num = -200 * d + (100 - 2 * longint'(offs_r)) * n;
        else
            num = 200 * d - 100 * n;
        q = num / n;
        if (q > 127) q = 127;
        if (q < -127) q = -127;
        return q;
    endfunction

    function automatic longint fshr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint int_sqrt(longint v);
        longint r, b;
        r = 0;
        for (b = 63; b >= 0; b--)
            if ((r + (longint'(1) << b)) * (r + (longint'(1) << b)) <= v && b < 31)
                r += longint'(1) << b;
        return r;
    endfunction

    function automatic longint atan_step(int i);
        longint tab[16] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                            29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};
        return tab[i];
    endfunction

    // Vectoring rotation on (y, |x|), rounded to FB fraction bits
    function automatic longint steer_of(longint x, longint y);
        longint re, im, z, t, dre, dim;
        re = y * 65536;
        im = (x < 0 ? -x : x) * 65536;
        z = 0;
        if (re < 0)
        begin
            t = re;
            re = im;
            im = -t;
            z = 90 * 65536;
        end
        for (int i = 0; i < 16; i++)
        begin
            dre = fshr(im, i);
            dim = fshr(re, i);
            if (im > 0)
            begin
                re += dre; im -= dim; z += atan_step(i);
            end
            else
            begin
                re -= dre; im += dim; z -= atan_step(i);
            end
        end
        z = fshr(z + (longint'(1) << (15 - FB)), 16 - FB);
        return x < 0 ? -z : z;
    endfunction

    function automatic polar_t predict_polar(logic [7:0] raw);
        polar_t p;
        longint s, sp, ang;
        logic   dz;
        p.axis = phase;
        if (phase == AXIS_X)
            xpos = map_raw(raw, 1'b0);
        else
            ypos = map_raw(raw, 1'b1);
        phase = ~phase;
        s  = xpos * xpos + ypos * ypos;
        dz = xpos < 5 && xpos > -5 && ypos < 5 && ypos > -5;
        if (s > SPEED_SQ_MAX)
            sp = 100 << FB;
        else if (dz)
            sp = 0;
        else
            sp = int_sqrt(s << (2 * FB));
        if (xpos == 0)
            ang = ypos < 0 ? (180 << FB) : 0;
        else if (ypos == 0)
            ang = xpos < 0 ? -(90 << FB) : (90 << FB);
        else if (dz)
            ang = 0;
        else
            ang = steer_of(xpos, ypos);
        p.speed = sp[SPEED_W-1:0];
        p.angle = ang[ANGLE_W-1:0];
        return p;
    endfunction

    // Track configuration, predict on input transfers, compare on output transfers
    always @(posedge clk or negedge rst_n)
    begin
        polar_t e;
        if (!rst_n)
        begin
            min_r = 8'd0;
            max_r = 8'd255;
            offs_r = 8'sd0;
            phase = AXIS_X;
            xpos = 0;
            ypos = 0;
            fail_count = 0;
            polar_q.delete();
            pending = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_RAW_MIN:     min_r = cfg_data;
                    CFG_RAW_MAX:     max_r = cfg_data;
                    CFG_AXIS_OFFSET: offs_r = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                polar_q.push_back(predict_polar(s_tdata));
            if (m_tvalid && m_tready)
            begin
                if (polar_q.size() == 0)
                begin
                    $error("unexpected result %h", m_tdata);
                    fail_count++;
                end
                else
                begin
                    e = polar_q.pop_front();
                    if (m_tdata[14:0] !== e.speed)
                    begin
                        $error("speed exp %0d got %0d", e.speed, m_tdata[14:0]);
                        fail_count++;
                    end
                    if (m_tdata[31:15] !== e.angle)
                    begin
                        $error("steer_angle exp %0d got %0d", $signed(e.angle),
                               $signed(m_tdata[31:15]));
                        fail_count++;
                    end
                    if (m_tuser !== e.axis)
                    begin
                        $error("updated_axis exp %0d got %0d", e.axis, m_tuser);
                        fail_count++;
                    end
                end
            end
            pending = polar_q.size();
        end
    end

endmodule

>>> dv/tb_top.sv
// Testbench top for the joystick polar converter: stimulus, idling and verdict.
`timescale 1ns / 1ps

module tb_top;
    import jpc_pkg::*;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [31:0]          m_tdata;
    logic                 m_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [RAW_W-1:0]     cfg_data = '0;
    int                   fail_count;
    int                   pending;
    int                   cycle_count = 0;
    bit                   calm = 1'b0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    joystick_polar_converter dut (.*);

    jpc_checker checker_i (.*);

    // Randomly stall the result side, except during the calm stretch
    always @(posedge clk)
        m_tready <= calm || ($urandom_range(99) >= 24);

    // Abort on a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Present one register write and wait for its transfer; the caller drops valid
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic send_byte(logic [7:0] raw);
        while (!calm && $urandom_range(99) < 24)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= raw;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic set_map(logic [7:0] lo, logic [7:0] hi, logic [7:0] off);
        write_reg(CFG_RAW_MIN, lo);
        write_reg(CFG_RAW_MAX, hi);
        write_reg(CFG_AXIS_OFFSET, off);
        cfg_valid <= 1'b0;
    endtask

    // Any byte value, uniformly at random
    function automatic logic [7:0] pick_raw();
        return 8'($urandom_range(255));
    endfunction

    initial
    begin
        logic [7:0] dir_bytes[16] = '{8'd0, 8'd255, 8'd127, 8'd128, 8'd128, 8'd0,
                                      8'd255, 8'd128, 8'd130, 8'd125, 8'd128, 8'd255,
                                      8'd0, 8'd128, 8'd0, 8'd0};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, axes, dead zone, quadrants
        foreach (dir_bytes[i])
            send_byte(dir_bytes[i]);
        drain();
        // Equal min and max, then inverted range with extreme offsets
        set_map(8'd50, 8'd50, 8'h9C);
        send_byte(8'd0);
        send_byte(8'd255);
        drain();
        set_map(8'd255, 8'd0, 8'd100);
        for (int i = 0; i < 6; i++)
            send_byte(dir_bytes[i]);
        drain();

        // Random phases with varied mappings
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: set_map(8'd0, 8'd255, 8'd0);
                1: set_map(8'd255, 8'd0, 8'h9C);
                2: set_map(8'd0, 8'd255, 8'd100);
                default: set_map(8'($urandom_range(255)), 8'($urandom_range(255)),
                                 8'($urandom_range(200) - 100));
            endcase
            calm = (ph == 3);
            for (int i = 0; i < 115; i++)
                send_byte(pick_raw());
            drain();
        end
        calm = 1'b0;

        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
